FILE: src/ffd_pkg.sv
package ffd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;
    localparam int TARGET_W   = 23;
    localparam int GAIN_W     = 16;
    localparam int SM_W       = 31;
    localparam int MPL_W      = 16;

    localparam int SMOOTH_COEF = 655;
    localparam int LP_ALPHA    = 22938;
    localparam int LP_KEEP     = 42598;
    localparam int UNITY_Q15   = 32768;
    localparam int TARGET_MAX  = 8388607;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_TARGET = 2'd0;
    localparam cfg_index_t REG_MIX    = 2'd1;
    localparam cfg_index_t REG_GAIN   = 2'd2;

endpackage

FILE: src/ffd_in_if.sv
interface ffd_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink (input valid, input in_sample, output ready);
endinterface

FILE: src/ffd_out_if.sv
interface ffd_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink (input valid, input out_sample, output ready);
endinterface

FILE: src/ffd_cfg_if.sv
interface ffd_cfg_if;
    logic                                valid;
    logic                                ready;
    ffd_pkg::cfg_index_t                 index;
    logic [ffd_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/ffd_ram.sv
module ffd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/fractional_feedback_delay_core.sv
// Feedback delay line with a smoothed fractional delay, Catmull-Rom read-out and a one-pole
// lowpass on the wet path. One sample in gives one mixed sample out. Every product goes
// through one shared bit-serial multiplier that retires one multiplier bit per clock, so an
// item takes nine multiplies plus the sequencing states and the four tap reads of the
// single-read-port ring RAM, and longer if the previous result is still waiting to be taken.
// After reset the ring is cleared, one entry per clock, before the first sample is accepted;
// configuration writes are taken only while the ring is being cleared or the core is idle
// with no input transaction offered, never in the middle of an item.
module fractional_feedback_delay_core #(
    parameter int DEPTH       = 32768,
    parameter int SAMPLE_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    ffd_in_if.sink    dry,
    ffd_out_if.source mixed,
    ffd_cfg_if.sink   cfg
);

    localparam int W  = SAMPLE_BITS;
    localparam int AB = $clog2(DEPTH);
    localparam int IW = W + 6;
    localparam int AW = (W + 24 > 43) ? W + 24 : 43;
    localparam int PW = ((AB > 15) ? AB : 15) + 18;

    localparam longint TLIM_RAW = (longint'(DEPTH) - 3) * 256;
    localparam logic [ffd_pkg::TARGET_W-1:0] TARGET_LIM =
        (TLIM_RAW > ffd_pkg::TARGET_MAX) ? ffd_pkg::TARGET_W'(ffd_pkg::TARGET_MAX)
                                         : ffd_pkg::TARGET_W'(TLIM_RAW);
    localparam logic [ffd_pkg::GAIN_W-1:0] UNITY = ffd_pkg::GAIN_W'(ffd_pkg::UNITY_Q15);

    localparam logic signed [W-1:0]  S_MAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  S_MIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0]  FB_LIM  = W'(3) << (W - 3);
    localparam logic signed [W-1:0]  FB_NEG  = -FB_LIM;
    localparam logic signed [AW-1:0] RND16   = AW'(1) << 15;
    localparam logic signed [AW-1:0] RND15   = AW'(1) << 14;
    localparam logic signed [PW-1:0] DEPTH_Q = PW'(DEPTH) << 16;
    localparam logic [AB-1:0]        LAST    = AB'(DEPTH - 1);

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_MUL   = 5'd2;
    localparam logic [4:0] S_SMUP  = 5'd3;
    localparam logic [4:0] S_POS   = 5'd4;
    localparam logic [4:0] S_RD0   = 5'd5;
    localparam logic [4:0] S_RD1   = 5'd6;
    localparam logic [4:0] S_RD2   = 5'd7;
    localparam logic [4:0] S_RD3   = 5'd8;
    localparam logic [4:0] S_RD4   = 5'd9;
    localparam logic [4:0] S_COEF  = 5'd10;
    localparam logic [4:0] S_V1    = 5'd11;
    localparam logic [4:0] S_V2    = 5'd12;
    localparam logic [4:0] S_V3    = 5'd13;
    localparam logic [4:0] S_LP2   = 5'd14;
    localparam logic [4:0] S_WET   = 5'd15;
    localparam logic [4:0] S_MIX2  = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;
    localparam logic [4:0] S_FB    = 5'd18;

    function automatic logic [AB-1:0] wrap_inc(input logic [AB-1:0] i);
        return (i == LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AB-1:0] wrap_dec(input logic [AB-1:0] i);
        return (i == '0) ? LAST : i - 1'b1;
    endfunction

    // control state
    logic [4:0]                        state_reg, state_next;
    logic [4:0]                        ret_reg, ret_next;
    logic [AB-1:0]                     clr_cnt_reg, clr_cnt_next;
    logic [ffd_pkg::TARGET_W-1:0]      target_reg, target_next;
    logic [ffd_pkg::GAIN_W-1:0]        mix_reg, mix_next;
    logic [ffd_pkg::GAIN_W-1:0]        gain_reg, gain_next;
    logic [ffd_pkg::SM_W-1:0]          sm_reg, sm_next;
    logic [AB-1:0]                     wp_reg, wp_next;
    logic signed [W-1:0]               lp_reg, lp_next;
    logic                              out_valid_reg, out_valid_next;
    logic [4:0]                        mcnt_reg, mcnt_next;

    // datapath
    logic signed [W-1:0]               x_reg, x_next;
    logic [AB-1:0]                     idx_reg, idx_next;
    logic [15:0]                       f_reg, f_next;
    logic signed [W-1:0]               s0_reg, s0_next;
    logic signed [W-1:0]               s1_reg, s1_next;
    logic signed [W-1:0]               s2_reg, s2_next;
    logic signed [W-1:0]               s3_reg, s3_next;
    logic signed [IW-1:0]              b_reg, b_next;
    logic signed [IW-1:0]              c_reg, c_next;
    logic signed [IW-1:0]              d_reg, d_next;
    logic signed [W-1:0]               wet_reg, wet_next;
    logic signed [W-1:0]               out_reg, out_next;
    logic signed [AW-1:0]              acc_reg, acc_next;
    logic signed [AW-1:0]              mcand_reg, mcand_next;
    logic [ffd_pkg::MPL_W-1:0]         mpl_reg, mpl_next;

    logic signed [31:0]                diff;
    logic signed [AW-1:0]              rnd16;
    logic signed [AW-1:0]              rnd15;
    logic signed [AW-1:0]              sm_sum;
    logic signed [PW-1:0]              pos_raw;
    logic signed [PW-1:0]              pos;
    logic signed [IW-1:0]              a_val;
    logic signed [IW-1:0]              v_val;
    logic signed [IW-1:0]              interp;
    logic signed [AW-1:0]              fb_sum;
    logic [ffd_pkg::GAIN_W-1:0]        cfg_low;

    logic                              ram_we;
    logic [AB-1:0]                     ram_waddr;
    logic [W-1:0]                      ram_wdata;
    logic [AB-1:0]                     ram_raddr;
    logic [W-1:0]                      ram_rdata;

    ffd_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign dry.ready        = (state_reg == S_IDLE);
    assign cfg.ready        = (state_reg == S_CLEAR) || ((state_reg == S_IDLE) && !dry.valid);
    assign mixed.valid      = out_valid_reg;
    assign mixed.out_sample = out_reg;

    assign diff    = $signed({1'b0, target_reg, 8'h00}) - $signed({1'b0, sm_reg});
    assign rnd16   = (acc_reg + RND16) >>> 16;
    assign rnd15   = (acc_reg + RND15) >>> 15;
    assign sm_sum  = AW'($signed({1'b0, sm_reg})) + rnd16;
    assign pos_raw = $signed(PW'({wp_reg, 16'h0000})) - $signed(PW'(sm_reg));
    assign pos     = pos_raw[PW-1] ? pos_raw + DEPTH_Q : pos_raw;
    assign a_val   = IW'(s3_reg) - IW'(s0_reg) + IW'(s1_reg) * IW'(3) - IW'(s2_reg) * IW'(3);
    assign fb_sum  = AW'(x_reg) + rnd15;
    assign cfg_low = cfg.data[ffd_pkg::GAIN_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        clr_cnt_next   = clr_cnt_reg;
        target_next    = target_reg;
        mix_next       = mix_reg;
        gain_next      = gain_reg;
        sm_next        = sm_reg;
        wp_next        = wp_reg;
        lp_next        = lp_reg;
        out_valid_next = out_valid_reg && !mixed.ready;
        mcnt_next      = mcnt_reg;
        x_next         = x_reg;
        idx_next       = idx_reg;
        f_next         = f_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        s3_next        = s3_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        wet_next       = wet_reg;
        out_next       = out_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mpl_next       = mpl_reg;
        v_val          = '0;
        interp         = '0;
        ram_we         = 1'b0;
        ram_waddr      = wp_reg;
        ram_wdata      = '0;
        ram_raddr      = idx_reg;

        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                ffd_pkg::REG_TARGET:
                begin
                    target_next = (cfg.data > TARGET_LIM) ? TARGET_LIM : cfg.data;
                end
                ffd_pkg::REG_MIX:
                begin
                    mix_next = (cfg_low > UNITY) ? UNITY : cfg_low;
                end
                ffd_pkg::REG_GAIN:
                begin
                    gain_next = (cfg_low > UNITY) ? UNITY : cfg_low;
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (dry.valid)
                begin
                    x_next     = dry.in_sample;
                    mcand_next = AW'(diff);
                    mpl_next   = ffd_pkg::MPL_W'(ffd_pkg::SMOOTH_COEF);
                    acc_next   = '0;
                    mcnt_next  = 5'(ffd_pkg::MPL_W);
                    ret_next   = S_SMUP;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mpl_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next = mcand_reg <<< 1;
                mpl_next   = mpl_reg >> 1;
                mcnt_next  = mcnt_reg - 1'b1;
                if (mcnt_reg == 5'd1)
                begin
                    state_next = ret_reg;
                end
            end
            S_SMUP:
            begin
                sm_next    = sm_sum[ffd_pkg::SM_W-1:0];
                state_next = S_POS;
            end
            S_POS:
            begin
                idx_next   = pos[AB+15:16];
                f_next     = pos[15:0];
                state_next = S_RD0;
            end
            S_RD0:
            begin
                ram_raddr  = wrap_dec(idx_reg);
                state_next = S_RD1;
            end
            S_RD1:
            begin
                ram_raddr  = idx_reg;
                s0_next    = ram_rdata;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                ram_raddr  = wrap_inc(idx_reg);
                s1_next    = ram_rdata;
                state_next = S_RD3;
            end
            S_RD3:
            begin
                ram_raddr  = wrap_inc(wrap_inc(idx_reg));
                s2_next    = ram_rdata;
                state_next = S_RD4;
            end
            S_RD4:
            begin
                s3_next    = ram_rdata;
                state_next = S_COEF;
            end
            S_COEF:
            begin
                b_next     = IW'(s0_reg) * IW'(2) - IW'(s1_reg) * IW'(5)
                             + IW'(s2_reg) * IW'(4) - IW'(s3_reg);
                c_next     = IW'(s2_reg) - IW'(s0_reg);
                d_next     = IW'(s1_reg) * IW'(2);
                mcand_next = AW'(a_val);
                mpl_next   = f_reg;
                acc_next   = '0;
                mcnt_next  = 5'(ffd_pkg::MPL_W);
                ret_next   = S_V1;
                state_next = S_MUL;
            end
            S_V1:
            begin
                v_val      = IW'(rnd16) + b_reg;
                mcand_next = AW'(v_val);
                mpl_next   = f_reg;
                acc_next   = '0;
                mcnt_next  = 5'(ffd_pkg::MPL_W);
                ret_next   = S_V2;
                state_next = S_MUL;
            end
            S_V2:
            begin
                v_val      = IW'(rnd16) + c_reg;
                mcand_next = AW'(v_val);
                mpl_next   = f_reg;
                acc_next   = '0;
                mcnt_next  = 5'(ffd_pkg::MPL_W);
                ret_next   = S_V3;
                state_next = S_MUL;
            end
            S_V3:
            begin
                v_val      = IW'(rnd16) + d_reg;
                interp     = (v_val + IW'(1)) >>> 1;
                mcand_next = AW'(interp);
                mpl_next   = ffd_pkg::MPL_W'(ffd_pkg::LP_ALPHA);
                acc_next   = '0;
                mcnt_next  = 5'(ffd_pkg::MPL_W);
                ret_next   = S_LP2;
                state_next = S_MUL;
            end
            S_LP2:
            begin
                mcand_next = AW'(lp_reg);
                mpl_next   = ffd_pkg::MPL_W'(ffd_pkg::LP_KEEP);
                mcnt_next  = 5'(ffd_pkg::MPL_W);
                ret_next   = S_WET;
                state_next = S_MUL;
            end
            S_WET:
            begin
                if (rnd16 > AW'(S_MAX))
                begin
                    wet_next = S_MAX;
                end
                else if (rnd16 < AW'(S_MIN))
                begin
                    wet_next = S_MIN;
                end
                else
                begin
                    wet_next = W'(rnd16);
                end
                lp_next    = wet_next;
                mcand_next = AW'(x_reg);
                mpl_next   = UNITY - mix_reg;
                acc_next   = '0;
                mcnt_next  = 5'(ffd_pkg::MPL_W);
                ret_next   = S_MIX2;
                state_next = S_MUL;
            end
            S_MIX2:
            begin
                mcand_next = AW'(wet_reg);
                mpl_next   = mix_reg;
                mcnt_next  = 5'(ffd_pkg::MPL_W);
                ret_next   = S_OUT;
                state_next = S_MUL;
            end
            S_OUT:
            begin
                if (!out_valid_reg || mixed.ready)
                begin
                    if (rnd15 > AW'(S_MAX))
                    begin
                        out_next = S_MAX;
                    end
                    else if (rnd15 < AW'(S_MIN))
                    begin
                        out_next = S_MIN;
                    end
                    else
                    begin
                        out_next = W'(rnd15);
                    end
                    out_valid_next = 1'b1;
                    mcand_next     = AW'(wet_reg);
                    mpl_next       = gain_reg;
                    acc_next       = '0;
                    mcnt_next      = 5'(ffd_pkg::MPL_W);
                    ret_next       = S_FB;
                    state_next     = S_MUL;
                end
            end
            S_FB:
            begin
                ram_we    = 1'b1;
                ram_waddr = wp_reg;
                if (fb_sum > AW'(FB_LIM))
                begin
                    ram_wdata = FB_LIM;
                end
                else if (fb_sum < AW'(FB_NEG))
                begin
                    ram_wdata = FB_NEG;
                end
                else
                begin
                    ram_wdata = W'(fb_sum);
                end
                wp_next    = wrap_inc(wp_reg);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ret_reg       <= S_IDLE;
            clr_cnt_reg   <= '0;
            target_reg    <= '0;
            mix_reg       <= '0;
            gain_reg      <= '0;
            sm_reg        <= '0;
            wp_reg        <= '0;
            lp_reg        <= '0;
            out_valid_reg <= 1'b0;
            mcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            clr_cnt_reg   <= clr_cnt_next;
            target_reg    <= target_next;
            mix_reg       <= mix_next;
            gain_reg      <= gain_next;
            sm_reg        <= sm_next;
            wp_reg        <= wp_next;
            lp_reg        <= lp_next;
            out_valid_reg <= out_valid_next;
            mcnt_reg      <= mcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        idx_reg   <= idx_next;
        f_reg     <= f_next;
        s0_reg    <= s0_next;
        s1_reg    <= s1_next;
        s2_reg    <= s2_next;
        s3_reg    <= s3_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        wet_reg   <= wet_next;
        out_reg   <= out_next;
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mpl_reg   <= mpl_next;
    end

    // no input transaction taken while the ring is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !dry.ready)
        else $error("input taken during ring clear");

    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (mcnt_reg != 5'd0))
        else $error("serial multiplier running with zero count");

    a_wp_moves_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(wp_reg) |-> $past(state_reg == S_FB))
        else $error("write pointer moved outside ring write");

endmodule

FILE: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH  = 32768;
    localparam int SBITS  = 16;
    localparam int WDOG   = 60000;

    logic clk;
    logic rst_n;

    ffd_in_if  #(.SAMPLE_BITS(SBITS)) dry_if ();
    ffd_out_if #(.SAMPLE_BITS(SBITS)) mix_if ();
    ffd_cfg_if                        cfg_if ();

    fractional_feedback_delay_core #(.DEPTH(DEPTH), .SAMPLE_BITS(SBITS)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .dry   (dry_if.sink),
        .mixed (mix_if.source),
        .cfg   (cfg_if.sink)
    );

    // predictor state
    logic signed [15:0] echo_mem [DEPTH];
    int unsigned        wr_ptr;
    longint             glide_delay;
    longint             lp_hist;
    longint             target_q8;
    longint             mix_q15;
    longint             gain_q15;

    logic signed [15:0] sample_queue [$];
    logic signed [15:0] mixed_expected [$];

    int  mismatches;
    int  results_seen;
    int  idle_cycles;

    function automatic longint rshift_round(longint x, int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint ring_tap(longint base, longint k);
        return longint'(echo_mem[(base + DEPTH + k) % DEPTH]);
    endfunction

    function automatic logic signed [15:0] echo_step(logic signed [15:0] dry_s);
        longint x, pos, idx, f, s0, s1, s2, s3, a, b, c, d, v, interp, wet, mixv, fb;
        x = longint'(dry_s);
        glide_delay += rshift_round(((target_q8 <<< 8) - glide_delay) * ffd_pkg::SMOOTH_COEF,
                                    16);
        pos = (longint'(wr_ptr) <<< 16) - glide_delay;
        if (pos < 0)
            pos += longint'(DEPTH) <<< 16;
        idx = (pos >>> 16) % DEPTH;
        f = pos & 64'hFFFF;
        s0 = ring_tap(idx, -1);
        s1 = ring_tap(idx, 0);
        s2 = ring_tap(idx, 1);
        s3 = ring_tap(idx, 2);
        a = -s0 + 3 * s1 - 3 * s2 + s3;
        b = 2 * s0 - 5 * s1 + 4 * s2 - s3;
        c = s2 - s0;
        d = 2 * s1;
        v = rshift_round(a * f, 16) + b;
        v = rshift_round(v * f, 16) + c;
        v = rshift_round(v * f, 16) + d;
        interp = rshift_round(v, 1);
        wet = clip(rshift_round(ffd_pkg::LP_ALPHA * interp + ffd_pkg::LP_KEEP * lp_hist, 16),
                   -32768, 32767);
        lp_hist = wet;
        mixv = clip(rshift_round(x * (ffd_pkg::UNITY_Q15 - mix_q15) + wet * mix_q15, 15),
                    -32768, 32767);
        fb = clip(x + rshift_round(wet * gain_q15, 15), -24576, 24576);
        echo_mem[wr_ptr] = 16'(fb);
        wr_ptr = (wr_ptr + 1) % DEPTH;
        return 16'(mixv);
    endfunction

    function automatic void apply_register(ffd_pkg::cfg_index_t idx,
                                           logic [ffd_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            ffd_pkg::REG_TARGET: target_q8 = clip(longint'(val), 0, longint'(DEPTH - 3) <<< 8);
            ffd_pkg::REG_MIX:    mix_q15 = clip(longint'(val[15:0]), 0, ffd_pkg::UNITY_Q15);
            ffd_pkg::REG_GAIN:   gain_q15 = clip(longint'(val[15:0]), 0, ffd_pkg::UNITY_Q15);
            default:    ;
        endcase
    endfunction

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // driver
    int send_wait;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dry_if.valid     <= 1'b0;
            dry_if.in_sample <= '0;
            send_wait        <= 0;
        end
        else
        begin
            if (dry_if.valid && dry_if.ready)
            begin
                mixed_expected.push_back(echo_step(dry_if.in_sample));
                send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
            end
            if ((dry_if.valid && dry_if.ready) || !dry_if.valid)
            begin
                if (sample_queue.size() > 0 && send_wait == 0
                    && !(dry_if.valid && dry_if.ready))
                begin
                    dry_if.valid     <= 1'b1;
                    dry_if.in_sample <= sample_queue.pop_front();
                end
                else
                    dry_if.valid <= 1'b0;
            end
            if (send_wait > 0 && !(dry_if.valid && dry_if.ready))
                send_wait <= send_wait - 1;
        end
    end

    // monitor
    int take_wait;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_if.ready <= 1'b0;
            take_wait    <= 0;
        end
        else
        begin
            if (mix_if.valid && mix_if.ready)
            begin
                results_seen <= results_seen + 1;
                if (mixed_expected.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected transaction: out_sample %0d", mix_if.out_sample);
                end
                else
                begin
                    logic signed [15:0] want;
                    want = mixed_expected.pop_front();
                    if (want !== mix_if.out_sample)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("out_sample mismatch: expected %0d, got %0d",
                                     want, mix_if.out_sample);
                    end
                end
                take_wait    <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
                mix_if.ready <= 1'b0;
            end
            else if (take_wait > 0)
            begin
                take_wait    <= take_wait - 1;
                mix_if.ready <= 1'b0;
            end
            else
                mix_if.ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (dry_if.valid && dry_if.ready) || (mix_if.valid && mix_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG + DEPTH)
        begin
            $display("watchdog expired");
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic write_register(ffd_pkg::cfg_index_t idx,
                                  logic [ffd_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        apply_register(idx, val);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain;
        wait (sample_queue.size() == 0 && !dry_if.valid && mixed_expected.size() == 0);
        repeat (200) @(posedge clk);
    endtask

    task automatic load_random(int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 5))
                0:       sample_queue.push_back(16'sh7FFF);
                1:       sample_queue.push_back(-16'sd32768);
                2:       sample_queue.push_back(16'($urandom_range(0, 63)));
                default: sample_queue.push_back(16'($urandom));
            endcase
        end
    endtask

    task automatic configure(logic [ffd_pkg::CFG_DATA_W-1:0] t,
                             logic [ffd_pkg::CFG_DATA_W-1:0] m,
                             logic [ffd_pkg::CFG_DATA_W-1:0] g);
        write_register(ffd_pkg::REG_TARGET, t);
        write_register(ffd_pkg::REG_MIX, m);
        write_register(ffd_pkg::REG_GAIN, g);
    endtask

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            echo_mem[i] = '0;
        wr_ptr = 0; glide_delay = 0; lp_hist = 0;
        target_q8 = 0; mix_q15 = 0; gain_q15 = 0;
        mismatches = 0; results_seen = 0; idle_cycles = 0;
        cfg_if.valid = 1'b0; cfg_if.index = ffd_pkg::REG_TARGET; cfg_if.data = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes with defaults, then short delay and full feedback
        sample_queue.push_back(16'sh7FFF);
        sample_queue.push_back(-16'sd32768);
        sample_queue.push_back(16'sd0);
        sample_queue.push_back(16'sh5555);
        sample_queue.push_back(-16'sh5556);
        drain();
        configure(23'd0, 23'd32768, 23'd32768);
        for (int i = 0; i < 8; i++)
            sample_queue.push_back((i % 2) ? 16'sh7FFF : -16'sd32768);
        drain();
        // out-of-range register values, unknown index
        configure(23'h7FFFFF, 23'hFFFF, 23'hFFFF);
        write_register(ffd_pkg::cfg_index_t'(3), 23'h123456);
        configure(23'd256 + 23'd128, 23'd16384, 23'd20000);
        for (int i = 0; i < 10; i++)
            sample_queue.push_back(16'($urandom));
        drain();

        // each phase waits until every expected result has come back
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: configure(23'd1 <<< 8, 23'd32768, 23'd32768);
                1: configure(23'($urandom_range(256, 16384)), 23'($urandom_range(0, 32768)),
                             23'($urandom_range(0, 32768)));
                2: configure(23'h7FFFFF, 23'd0, 23'd0);
                3: configure(23'($urandom_range(0, 8388607)), 23'($urandom), 23'($urandom));
                4: configure(23'd3, 23'd32768, 23'd30000);
                default: configure(23'($urandom_range(512, 4096)), 23'd12000, 23'd24000);
            endcase
            load_random(310);
            drain();
        end
        $display("covered %0d results over six random register settings plus directed cases",
                 results_seen);
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule
